// File: rtl/core/frame_present_wait_scheduler_top_defines.svh
// Assertion macros shared by the frame present wait scheduler RTL.
`ifndef FRAME_PRESENT_WAIT_SCHEDULER_TOP_DEFINES_SVH
`define FRAME_PRESENT_WAIT_SCHEDULER_TOP_DEFINES_SVH

// Same-cycle implication, disabled while reset is asserted.
`define FPWS_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define FPWS_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// File: rtl/core/fpws_pkg.sv
// Types, constants and helper functions of the frame present wait scheduler.
package fpws_pkg;

  localparam int unsigned RegW   = 16;
  localparam int unsigned TimeW  = 32;
  localparam int unsigned WaitW  = 31;
  localparam int unsigned KindW  = 3;
  localparam int unsigned CfgIdxW = 3;

  localparam logic [WaitW-1:0] WAIT_MAX = {WaitW{1'b1}};

  // Transaction kinds
  localparam logic [KindW-1:0] KIND_INIT        = 3'd0;
  localparam logic [KindW-1:0] KIND_INVALIDATE  = 3'd1;
  localparam logic [KindW-1:0] KIND_CLEAR       = 3'd2;
  localparam logic [KindW-1:0] KIND_PRESENTED   = 3'd3;
  localparam logic [KindW-1:0] KIND_QUERY       = 3'd4;

  // Register indexes
  localparam logic [CfgIdxW-1:0] REG_STATIC_PERIOD = 3'd0;
  localparam logic [CfgIdxW-1:0] REG_ANIM_PERIOD   = 3'd1;
  localparam logic [CfgIdxW-1:0] REG_MARQUEE_PERIOD = 3'd2;
  localparam logic [CfgIdxW-1:0] REG_FADE_WINDOW   = 3'd3;
  localparam logic [CfgIdxW-1:0] REG_FADE_PERIOD   = 3'd4;
  localparam logic [CfgIdxW-1:0] REG_RAW_MAX_WAIT  = 3'd5;

  // Reset values
  localparam logic [RegW-1:0] STATIC_PERIOD_RST  = 16'd1000;
  localparam logic [RegW-1:0] ANIM_PERIOD_RST    = 16'd16;
  localparam logic [RegW-1:0] MARQUEE_PERIOD_RST = 16'd100;
  localparam logic [RegW-1:0] FADE_WINDOW_RST    = 16'd250;
  localparam logic [RegW-1:0] FADE_PERIOD_RST    = 16'd16;
  localparam logic [RegW-1:0] RAW_MAX_WAIT_RST   = 16'd8;

  typedef struct packed {
    logic [RegW-1:0] static_period_ms;
    logic [RegW-1:0] animation_period_ms;
    logic [RegW-1:0] marquee_period_ms;
    logic [RegW-1:0] fade_window_ms;
    logic [RegW-1:0] fade_period_ms;
    logic [RegW-1:0] raw_input_max_wait_ms;
  } cfg_t;

  typedef struct packed {
    logic [TimeW-1:0] last_present_time;
    logic             frame_dirty;
  } state_t;

  // Deadline has passed when (now - deadline) mod 2^32 is below 2^31.
  function automatic logic is_past(input logic [TimeW-1:0] now,
                                   input logic [TimeW-1:0] deadline);
    logic [TimeW-1:0] diff;
    diff = now - deadline;
    return ~diff[TimeW-1];
  endfunction

  // Time left to a deadline, zero once passed, saturated to 31 bits.
  function automatic logic [WaitW-1:0] remaining(input logic [TimeW-1:0] now,
                                                 input logic [TimeW-1:0] deadline);
    logic [TimeW-1:0] left;
    left = deadline - now;
    if (is_past(now, deadline)) begin
      return '0;
    end else if (left[TimeW-1]) begin
      return WAIT_MAX;
    end else begin
      return left[WaitW-1:0];
    end
  endfunction

  function automatic logic [WaitW-1:0] min_wait(input logic [WaitW-1:0] a,
                                                input logic [WaitW-1:0] b);
    return (b < a) ? b : a;
  endfunction

endpackage

// File: rtl/core/frame_present_wait_scheduler_top.sv
// Top level of the frame present wait scheduler: input stage, state, result register.
//
// Frame present wait scheduler. Event transactions (init, invalidate, clear,
// presented) update the last-present time and the dirty flag and produce no
// result; a query transaction produces one result with render_due and wait_ms,
// the soonest of the static, animation, marquee, overlay-end, fade and wake
// deadlines under 32-bit wraparound. Throughput is one transaction per clock
// while in_stall is low. A transaction is captured in the input register at
// acceptance and a query's result lands in the output register when the query
// leaves the input register. The only thing that holds the input side is a
// query sitting in the input register while the output register is full and
// stalled; then in_stall follows out_stall in the same cycle. Events never wait
// on the output side. Unused kinds 5..7 are consumed with no effect. Config
// registers are written through cfg_we/cfg_index/cfg_wdata by the user only
// while idle (not enforced by the block); writes to indexes above 5 are dropped.
`include "frame_present_wait_scheduler_top_defines.svh"

module frame_present_wait_scheduler_top (
  input  logic                               clk,
  input  logic                               rst_n,
  // input channel
  input  logic                               in_valid,
  output logic                               in_stall,
  input  logic [fpws_pkg::KindW-1:0]         in_kind,
  input  logic [fpws_pkg::TimeW-1:0]         in_now,
  input  logic                               in_visible,
  input  logic                               in_animate,
  input  logic                               in_marquee,
  input  logic                               in_action_active,
  input  logic [fpws_pkg::TimeW-1:0]         in_action_until,
  input  logic signed [fpws_pkg::TimeW-1:0]  in_required_wake_ms,
  input  logic                               in_raw_input,
  // result channel
  output logic                               out_valid,
  input  logic                               out_stall,
  output logic                               out_render_due,
  output logic [fpws_pkg::WaitW-1:0]         out_wait_ms,
  // config port
  input  logic                               cfg_we,
  input  logic [fpws_pkg::CfgIdxW-1:0]       cfg_index,
  input  logic [fpws_pkg::RegW-1:0]          cfg_wdata
);

  fpws_pkg::cfg_t   cfg;
  fpws_pkg::state_t st_r, st_nxt;

  // input stage
  logic                              s1_v_r, s1_v_nxt;
  logic [fpws_pkg::KindW-1:0]        s1_kind_r;
  logic [fpws_pkg::TimeW-1:0]        s1_now_r;
  logic                              s1_visible_r, s1_animate_r, s1_marquee_r;
  logic                              s1_action_active_r, s1_raw_input_r;
  logic [fpws_pkg::TimeW-1:0]        s1_action_until_r;
  logic signed [fpws_pkg::TimeW-1:0] s1_wake_r;

  // result register
  logic                              out_v_r, out_v_nxt;
  logic                              out_render_due_r;
  logic [fpws_pkg::WaitW-1:0]        out_wait_ms_r;

  logic                              in_accept, s1_query, s1_adv, out_take;
  logic                              calc_render_due;
  logic [fpws_pkg::WaitW-1:0]        calc_wait_ms;

  fpws_cfg_regs u_cfg (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .cfg       (cfg)
  );

  fpws_wait_calc u_calc (
    .cfg         (cfg),
    .st          (st_r),
    .now         (s1_now_r),
    .visible     (s1_visible_r),
    .animate     (s1_animate_r),
    .marquee     (s1_marquee_r),
    .overlay_on  (s1_action_active_r),
    .overlay_end (s1_action_until_r),
    .wake_req    (s1_wake_r),
    .raw_input   (s1_raw_input_r),
    .render_due  (calc_render_due),
    .wait_ms     (calc_wait_ms)
  );

  // Handshake: a query leaves the input stage only when the result slot frees up.
  assign out_take  = out_v_r & ~out_stall;
  assign s1_query  = (s1_kind_r == fpws_pkg::KIND_QUERY);
  assign s1_adv    = s1_v_r & (~s1_query | ~out_v_r | ~out_stall);
  assign in_stall  = s1_v_r & ~s1_adv;
  assign in_accept = in_valid & ~in_stall;

  always_comb begin
    s1_v_nxt = in_accept | (s1_v_r & ~s1_adv);
  end

  always_comb begin
    out_v_nxt = (s1_adv & s1_query) | (out_v_r & ~out_take);
  end

  // State update as each event transaction retires from the input stage.
  always_comb begin
    st_nxt = st_r;
    if (s1_adv) begin
      case (s1_kind_r)
        fpws_pkg::KIND_INIT: begin
          st_nxt.last_present_time = s1_now_r;
          st_nxt.frame_dirty       = 1'b1;
        end
        fpws_pkg::KIND_INVALIDATE: st_nxt.frame_dirty = 1'b1;
        fpws_pkg::KIND_CLEAR:      st_nxt.frame_dirty = 1'b0;
        fpws_pkg::KIND_PRESENTED: begin
          st_nxt.last_present_time = s1_now_r;
          st_nxt.frame_dirty       = 1'b0;
        end
        default: ; // query and unused kinds leave state alone
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r                <= 1'b0;
      out_v_r               <= 1'b0;
      st_r.last_present_time <= '0;
      st_r.frame_dirty       <= 1'b1;
    end else begin
      s1_v_r  <= s1_v_nxt;
      out_v_r <= out_v_nxt;
      st_r    <= st_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_accept) begin
      s1_kind_r          <= in_kind;
      s1_now_r           <= in_now;
      s1_visible_r       <= in_visible;
      s1_animate_r       <= in_animate;
      s1_marquee_r       <= in_marquee;
      s1_action_active_r <= in_action_active;
      s1_action_until_r  <= in_action_until;
      s1_wake_r          <= in_required_wake_ms;
      s1_raw_input_r     <= in_raw_input;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_adv && s1_query) begin
      out_render_due_r <= calc_render_due;
      out_wait_ms_r    <= calc_wait_ms;
    end
  end

  assign out_valid      = out_v_r;
  assign out_render_due = out_render_due_r;
  assign out_wait_ms    = out_wait_ms_r;

  // A due render always means a zero wait.
  `FPWS_ASSERT_NOW(a_due_zero_wait, out_v_r && out_render_due_r, out_wait_ms_r == '0, "render_due with nonzero wait")
  // Input side only holds off while a query is blocked behind a stalled result.
  `FPWS_ASSERT_NOW(a_stall_cause, in_stall, s1_v_r && s1_query && out_v_r && out_stall, "in_stall without a blocked query")
  // A retired presented transaction leaves a clean frame at its time.
  `FPWS_ASSERT_NEXT(a_presented_upd, s1_adv && (s1_kind_r == fpws_pkg::KIND_PRESENTED), !st_r.frame_dirty && (st_r.last_present_time == $past(s1_now_r)), "presented did not update state")
  // A retired query always fills the result register.
  `FPWS_ASSERT_NEXT(a_query_result, s1_adv && s1_query, out_v_r, "query retired without a result")

endmodule

// File: rtl/core/fpws_cfg_regs.sv
// Configuration register file of the frame present wait scheduler.
module fpws_cfg_regs (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         cfg_we,
  input  logic [fpws_pkg::CfgIdxW-1:0] cfg_index,
  input  logic [fpws_pkg::RegW-1:0]    cfg_wdata,
  output fpws_pkg::cfg_t               cfg
);

  fpws_pkg::cfg_t cfg_r;
  fpws_pkg::cfg_t cfg_nxt;

  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_we) begin
      case (cfg_index)
        fpws_pkg::REG_STATIC_PERIOD:  cfg_nxt.static_period_ms      = cfg_wdata;
        fpws_pkg::REG_ANIM_PERIOD:    cfg_nxt.animation_period_ms   = cfg_wdata;
        fpws_pkg::REG_MARQUEE_PERIOD: cfg_nxt.marquee_period_ms     = cfg_wdata;
        fpws_pkg::REG_FADE_WINDOW:    cfg_nxt.fade_window_ms        = cfg_wdata;
        fpws_pkg::REG_FADE_PERIOD:    cfg_nxt.fade_period_ms        = cfg_wdata;
        fpws_pkg::REG_RAW_MAX_WAIT:   cfg_nxt.raw_input_max_wait_ms = cfg_wdata;
        default: ; // unmapped index: ignored
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.static_period_ms      <= fpws_pkg::STATIC_PERIOD_RST;
      cfg_r.animation_period_ms   <= fpws_pkg::ANIM_PERIOD_RST;
      cfg_r.marquee_period_ms     <= fpws_pkg::MARQUEE_PERIOD_RST;
      cfg_r.fade_window_ms        <= fpws_pkg::FADE_WINDOW_RST;
      cfg_r.fade_period_ms        <= fpws_pkg::FADE_PERIOD_RST;
      cfg_r.raw_input_max_wait_ms <= fpws_pkg::RAW_MAX_WAIT_RST;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  assign cfg = cfg_r;

endmodule

// File: rtl/core/fpws_wait_calc.sv
// Combinational deadline evaluation for one query transaction.
module fpws_wait_calc (
  input  fpws_pkg::cfg_t                 cfg,
  input  fpws_pkg::state_t               st,
  input  logic [fpws_pkg::TimeW-1:0]     now,
  input  logic                           visible,
  input  logic                           animate,
  input  logic                           marquee,
  input  logic                           overlay_on,
  input  logic [fpws_pkg::TimeW-1:0]     overlay_end,
  input  logic signed [fpws_pkg::TimeW-1:0] wake_req,
  input  logic                           raw_input,
  output logic                           render_due,
  output logic [fpws_pkg::WaitW-1:0]     wait_ms
);

  localparam int unsigned ExtW = fpws_pkg::TimeW - fpws_pkg::RegW;
  localparam int unsigned WExtW = fpws_pkg::WaitW - fpws_pkg::RegW;

  logic [fpws_pkg::TimeW-1:0] lpt;
  logic [fpws_pkg::WaitW-1:0] c_static, c_anim, c_marquee, c_until;
  logic [fpws_pkg::WaitW-1:0] c_open, c_fadep, c_fade;
  logic [fpws_pkg::TimeW-1:0] rem_until, open_left, fw32;
  logic                       until_ahead, fade_open, act;
  logic [fpws_pkg::WaitW-1:0] m, rw, w, cap;
  logic                       wake_ok;
  logic [fpws_pkg::WaitW-1:0] wake31;

  assign lpt = st.last_present_time;

  assign c_static  = fpws_pkg::remaining(now, lpt + {{ExtW{1'b0}}, cfg.static_period_ms});
  assign c_anim    = fpws_pkg::remaining(now, lpt + {{ExtW{1'b0}}, cfg.animation_period_ms});
  assign c_marquee = fpws_pkg::remaining(now, lpt + {{ExtW{1'b0}}, cfg.marquee_period_ms});
  assign c_fadep   = fpws_pkg::remaining(now, lpt + {{ExtW{1'b0}}, cfg.fade_period_ms});
  assign c_until   = fpws_pkg::remaining(now, overlay_end);

  // Overlay terms: time until the fade window opens, or the fade frame period inside it.
  assign fw32        = {{ExtW{1'b0}}, cfg.fade_window_ms};
  assign rem_until   = overlay_end - now;
  assign until_ahead = ~fpws_pkg::is_past(now, overlay_end);
  assign fade_open   = rem_until > fw32;
  assign open_left   = rem_until - fw32;
  assign c_open      = open_left[fpws_pkg::TimeW-1] ? fpws_pkg::WAIT_MAX
                                                    : open_left[fpws_pkg::WaitW-1:0];
  assign c_fade      = fade_open ? c_open : c_fadep;
  assign act         = overlay_on & ~fpws_pkg::is_past(lpt, overlay_end);

  always_comb begin
    m = c_static;
    if (animate) begin
      m = fpws_pkg::min_wait(m, c_anim);
    end
    if (marquee) begin
      m = fpws_pkg::min_wait(m, c_marquee);
    end
    if (act) begin
      m = fpws_pkg::min_wait(m, c_until);
    end
    if (act && until_ahead) begin
      m = fpws_pkg::min_wait(m, c_fade);
    end
    rw = st.frame_dirty ? '0 : m;
  end

  assign wake_ok = ~wake_req[fpws_pkg::TimeW-1];
  assign wake31  = wake_req[fpws_pkg::WaitW-1:0];
  assign cap     = {{WExtW{1'b0}}, cfg.raw_input_max_wait_ms};

  always_comb begin
    if (visible) begin
      w = wake_ok ? fpws_pkg::min_wait(rw, wake31) : rw;
    end else if (wake_ok) begin
      w = wake31;
    end else begin
      w = {{WExtW{1'b0}}, cfg.static_period_ms};
    end
    if (raw_input && (w > cap)) begin
      w = cap;
    end
  end

  assign wait_ms    = w;
  assign render_due = visible & (rw == '0);

endmodule
